/* src/rgbpt_pkg.sv */
// Package for the RGB pixel point transform: mode codes, register indexes,
// sepia coefficients, the reciprocal used to divide by 1000 and the divider stage record.
// No dependencies.
package rgbpt_pkg;

  typedef enum logic [2:0] {
    MODE_BITMAP  = 3'd0,
    MODE_GRAY    = 3'd1,
    MODE_ISOLATE = 3'd2,
    MODE_REMOVE  = 3'd3,
    MODE_SEPIA   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_CHAN_SEL = 2'd1,
    REG_MAX_IN   = 2'd2,
    REG_GRAY_MAX = 2'd3
  } reg_idx_t;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // sepia matrix in thousandths, rows give red, green, blue
  localparam logic [9:0] K_RR = 10'd393, K_RG = 10'd769, K_RB = 10'd189;
  localparam logic [9:0] K_GR = 10'd349, K_GG = 10'd686, K_GB = 10'd168;
  localparam logic [9:0] K_BR = 10'd272, K_BG = 10'd534, K_BB = 10'd131;

  // floor(x/1000) == (x*RECIP_1000) >> RECIP_SHIFT, exact for x < 2^27
  localparam int unsigned RECIP_SHIFT = 37;
  localparam logic [27:0] RECIP_1000  = 28'd137438954;

  localparam int unsigned DIV_STEPS = 16;

  // one pixel in the divider part of the pipeline
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        thr;     // bitmap bit
    logic        sat;     // grey saturates at gray_max
    logic        zmax;    // max_in is zero
    logic [17:0] rem;     // partial remainder, below divisor
    logic [15:0] nlo;     // numerator bits still to shift in
    logic [15:0] quo;
    logic [17:0] dvs;     // 3*max_in
  } div_item_t;

  function automatic div_item_t div_step(div_item_t d);
    div_item_t   o;
    logic [18:0] t;
    o = d;
    t = {d.rem, d.nlo[15]};
    if (t >= {1'b0, d.dvs}) begin
      o.rem = 18'(t - {1'b0, d.dvs});
      o.quo = {d.quo[14:0], 1'b1};
    end else begin
      o.rem = t[17:0];
      o.quo = {d.quo[14:0], 1'b0};
    end
    o.nlo = {d.nlo[14:0], 1'b0};
    return o;
  endfunction

endpackage

/* src/rgbpt_div_pipe.sv */
// Pipelined restoring divider for the grey level: one quotient bit per stage.
// Depends on rgbpt_pkg; the stage enables come from the top level's flow control.
module rgbpt_div_pipe
  import rgbpt_pkg::*;
(
  input  logic                  clk,
  input  logic [DIV_STEPS-1:0]  en,
  input  div_item_t             d_in,
  output div_item_t             d_out
);

  div_item_t stage_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stage_r[0] <= div_step(d_in);
    end
    for (int i = 1; i < DIV_STEPS; i++) begin
      if (en[i]) begin
        stage_r[i] <= div_step(stage_r[i-1]);
      end
    end
  end

  assign d_out = stage_r[DIV_STEPS-1];

endmodule

/* src/rgb_pixel_point_transform_top.sv */
// Top level of the RGB pixel point transform.
// Depends on rgbpt_pkg and rgbpt_div_pipe.
//
// Takes one pixel per clock while the output is free and gives one result per pixel, in
// order. The length of the pipeline is set by the grey-level divide, which yields
// one quotient bit per stage over 16 stages; four stages before it form the sums, the
// sepia products and the divide by 1000, one output stage follows. Each stage holds its
// own valid bit and moves up whenever the stage after it is empty or moving, so bubbles
// close up and a stalled output still lets the earlier stages fill. Configuration writes
// are always taken and should be made only while no request is in flight.
module rgb_pixel_point_transform_top
  import rgbpt_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_red_in,
  input  logic [15:0] in_green_in,
  input  logic [15:0] in_blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red_out,
  output logic [15:0] out_green_out,
  output logic [15:0] out_blue_out,
  output logic [15:0] out_gray_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam int NPRE   = 4;
  localparam int NSTAGE = NPRE + DIV_STEPS + 1;

  // configuration
  logic [2:0]  mode_r;
  logic [1:0]  chan_r;
  logic [15:0] max_in_r;
  logic [15:0] gray_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_BITMAP;
      chan_r     <= CH_RED;
      max_in_r   <= 16'd255;
      gray_max_r <= 16'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:     mode_r     <= cfg_data[2:0];
        REG_CHAN_SEL: chan_r     <= cfg_data[1:0];
        REG_MAX_IN:   max_in_r   <= cfg_data;
        REG_GRAY_MAX: gray_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE:0]   en;

  always_comb begin
    en[NSTAGE] = !out_stall;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTAGE-1];

  // stage 0: capture
  logic [15:0] r0_r, g0_r, b0_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0_r <= in_red_in & SAMPLE_MASK;
      g0_r <= in_green_in & SAMPLE_MASK;
      b0_r <= in_blue_in & SAMPLE_MASK;
    end
  end

  // stage 1: pixel sum and sepia products
  logic [15:0] r1_r, g1_r, b1_r;
  logic [17:0] sum1_r;
  logic [25:0] p_r [9];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1_r   <= r0_r;
      g1_r   <= g0_r;
      b1_r   <= b0_r;
      sum1_r <= 18'(r0_r) + 18'(g0_r) + 18'(b0_r);
      p_r[0] <= K_RR * r0_r; p_r[1] <= K_RG * g0_r; p_r[2] <= K_RB * b0_r;
      p_r[3] <= K_GR * r0_r; p_r[4] <= K_GG * g0_r; p_r[5] <= K_GB * b0_r;
      p_r[6] <= K_BR * r0_r; p_r[7] <= K_BG * g0_r; p_r[8] <= K_BB * b0_r;
    end
  end

  // stage 2: dot products, grey numerator, divisor and flags
  logic [15:0] r2_r, g2_r, b2_r;
  logic [26:0] dot_r [3];
  logic [33:0] num2_r;
  logic [17:0] dvs2_r;
  logic        thr2_r, sat2_r, zmax2_r;
  logic [17:0] dvs_c;
  assign dvs_c = 18'(max_in_r) + {1'b0, max_in_r, 1'b0};
  always_ff @(posedge clk) begin
    if (en[2]) begin
      r2_r     <= r1_r;
      g2_r     <= g1_r;
      b2_r     <= b1_r;
      dot_r[0] <= 27'(p_r[0]) + 27'(p_r[1]) + 27'(p_r[2]);
      dot_r[1] <= 27'(p_r[3]) + 27'(p_r[4]) + 27'(p_r[5]);
      dot_r[2] <= 27'(p_r[6]) + 27'(p_r[7]) + 27'(p_r[8]);
      num2_r   <= sum1_r * gray_max_r;
      dvs2_r   <= dvs_c;
      thr2_r   <= {sum1_r, 1'b0} < {1'b0, dvs_c};
      sat2_r   <= sum1_r >= dvs_c;
      zmax2_r  <= max_in_r == 16'd0;
    end
  end

  // stage 3: divide the dot products by 1000 through the reciprocal
  logic [15:0] r3_r, g3_r, b3_r;
  logic [54:0] rc_r [3];
  logic [33:0] num3_r;
  logic [17:0] dvs3_r;
  logic        thr3_r, sat3_r, zmax3_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      r3_r    <= r2_r;
      g3_r    <= g2_r;
      b3_r    <= b2_r;
      for (int c = 0; c < 3; c++) begin
        rc_r[c] <= dot_r[c] * RECIP_1000;
      end
      num3_r  <= num2_r;
      dvs3_r  <= dvs2_r;
      thr3_r  <= thr2_r;
      sat3_r  <= sat2_r;
      zmax3_r <= zmax2_r;
    end
  end

  // stage 4 (combinational part): colour results, divider seed
  logic [17:0] sep_q [3];
  logic [15:0] sep   [3];
  div_item_t   seed_c;
  div_item_t   div_out;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sep_q[c] = rc_r[c][RECIP_SHIFT +: 18];
      sep[c]   = (sep_q[c] > 18'(max_in_r)) ? max_in_r : sep_q[c][15:0];
    end
    seed_c      = '0;
    seed_c.thr  = thr3_r;
    seed_c.sat  = sat3_r;
    seed_c.zmax = zmax3_r;
    seed_c.dvs  = dvs3_r;
    // numerator below dvs*2^16 when not saturated, so its high part is below dvs
    seed_c.rem  = sat3_r ? 18'd0 : num3_r[33:16];
    seed_c.nlo  = num3_r[15:0];
    case (mode_r)
      MODE_ISOLATE: begin
        seed_c.red   = (chan_r == CH_RED)   ? r3_r : 16'd0;
        seed_c.green = (chan_r == CH_GREEN) ? g3_r : 16'd0;
        seed_c.blue  = (chan_r == CH_BLUE)  ? b3_r : 16'd0;
      end
      MODE_REMOVE: begin
        seed_c.red   = (chan_r == CH_RED)   ? 16'd0 : r3_r;
        seed_c.green = (chan_r == CH_GREEN) ? 16'd0 : g3_r;
        seed_c.blue  = (chan_r == CH_BLUE)  ? 16'd0 : b3_r;
      end
      MODE_SEPIA: begin
        seed_c.red   = sep[0];
        seed_c.green = sep[1];
        seed_c.blue  = sep[2];
      end
      default: ;
    endcase
  end

  rgbpt_div_pipe u_div (
    .clk   (clk),
    .en    (en[NPRE +: DIV_STEPS]),
    .d_in  (seed_c),
    .d_out (div_out)
  );

  // output stage
  logic [15:0] gray_c;
  always_comb begin
    case (mode_r)
      MODE_BITMAP: gray_c = {15'd0, div_out.thr};
      MODE_GRAY: begin
        if (div_out.zmax)     gray_c = 16'd0;
        else if (div_out.sat) gray_c = gray_max_r;
        else                  gray_c = div_out.quo;
      end
      default: gray_c = 16'd0;
    endcase
  end

  logic [15:0] ro_r, go_r, bo_r, gy_r;
  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) begin
      ro_r <= div_out.red;
      go_r <= div_out.green;
      bo_r <= div_out.blue;
      gy_r <= gray_c;
    end
  end

  assign out_red_out   = ro_r;
  assign out_green_out = go_r;
  assign out_blue_out  = bo_r;
  assign out_gray_out  = gy_r;

endmodule

/* src/rgbpt_checker.sv */
// Port checker for the RGB pixel point transform, bound to the top level.
// Depends on rgb_pixel_point_transform_top only through the bind below.
module rgbpt_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_red_out,
  input logic [15:0] out_green_out,
  input logic [15:0] out_blue_out,
  input logic [15:0] out_gray_out
);

  // no result is left over from before reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a free output lets every stage move, so a request is never held off
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_red_out)
      && $stable(out_green_out) && $stable(out_blue_out) && $stable(out_gray_out)))
    else $error("stalled result changed");

endmodule

bind rgb_pixel_point_transform_top rgbpt_port_checker u_rgbpt_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out),
  .out_gray_out  (out_gray_out)
);

/* verif/rgbpt_checker.sv */
// Checker for the RGB pixel point transform: tracks register writes, predicts each result
// from the accepted pixel and compares it with the result stream in order.
// Depends on rgbpt_pkg.
module rgbpt_checker
  import rgbpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_red_in,
  input  logic [15:0] in_green_in,
  input  logic [15:0] in_blue_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_red_out,
  input  logic [15:0] out_green_out,
  input  logic [15:0] out_blue_out,
  input  logic [15:0] out_gray_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] gray;
  } pix_result_t;

  logic [2:0]  cur_mode;
  logic [1:0]  cur_chan;
  logic [15:0] cur_max_in;
  logic [15:0] cur_gray_max;
  pix_result_t expected_pixels[$];

  initial errors = 0;
  assign pending = expected_pixels.size();

  function automatic logic [15:0] sepia_term(logic [15:0] r, logic [15:0] g,
                                             logic [15:0] b, int kr, int kg, int kb);
    longint v;
    v = (kr * longint'(r) + kg * longint'(g) + kb * longint'(b)) / 1000;
    if (v > cur_max_in) v = cur_max_in;
    return v[15:0];
  endfunction

  function automatic pix_result_t transform_pixel(logic [15:0] r, logic [15:0] g,
                                                  logic [15:0] b);
    pix_result_t res;
    longint      sum;
    longint      q;
    res = '0;
    sum = longint'(r) + longint'(g) + longint'(b);
    case (cur_mode)
      MODE_BITMAP: res.gray = (2 * sum < 3 * longint'(cur_max_in)) ? 16'd1 : 16'd0;
      MODE_GRAY: begin
        if (cur_max_in != 0) begin
          q = (sum * cur_gray_max) / (3 * longint'(cur_max_in));
          if (q > cur_gray_max) q = cur_gray_max;
          res.gray = q[15:0];
        end
      end
      MODE_ISOLATE: begin
        res.red   = (cur_chan == CH_RED)   ? r : 16'd0;
        res.green = (cur_chan == CH_GREEN) ? g : 16'd0;
        res.blue  = (cur_chan == CH_BLUE)  ? b : 16'd0;
      end
      MODE_REMOVE: begin
        res.red   = (cur_chan == CH_RED)   ? 16'd0 : r;
        res.green = (cur_chan == CH_GREEN) ? 16'd0 : g;
        res.blue  = (cur_chan == CH_BLUE)  ? 16'd0 : b;
      end
      MODE_SEPIA: begin
        res.red   = sepia_term(r, g, b, K_RR, K_RG, K_RB);
        res.green = sepia_term(r, g, b, K_GR, K_GG, K_GB);
        res.blue  = sepia_term(r, g, b, K_BR, K_BG, K_BB);
      end
      default: ;  // unused modes give all zero
    endcase
    return res;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pix_result_t want;
    if (!rst_n) begin
      cur_mode     <= MODE_BITMAP;
      cur_chan     <= CH_RED;
      cur_max_in   <= 16'd255;
      cur_gray_max <= 16'd255;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     cur_mode     <= cfg_data[2:0];
          REG_CHAN_SEL: cur_chan     <= cfg_data[1:0];
          REG_MAX_IN:   cur_max_in   <= cfg_data;
          REG_GRAY_MAX: cur_gray_max <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("mismatch at %0t: result with no pixel outstanding", $time);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_red_out !== want.red)     report("red", out_red_out, want.red);
          if (out_green_out !== want.green) report("green", out_green_out, want.green);
          if (out_blue_out !== want.blue)   report("blue", out_blue_out, want.blue);
          if (out_gray_out !== want.gray)   report("gray", out_gray_out, want.gray);
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(transform_pixel(in_red_in, in_green_in, in_blue_in));
    end
  end

endmodule

/* verif/rgb_pixel_point_transform_top_tb.sv */
// Testbench top for the RGB pixel point transform: clock, reset, pixel and register
// stimulus, result-side stalls, watchdog and verdict.
// Depends on rgbpt_pkg, rgb_pixel_point_transform_top and rgbpt_checker.
module rgb_pixel_point_transform_top_tb;
  import rgbpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_red_out, out_green_out, out_blue_out, out_gray_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          errors, pending;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [15:0] pix_span = 16'hffff;

  always #5 clk = ~clk;

  rgb_pixel_point_transform_top dut (.*);
  rgbpt_checker u_checker (.*);

  // result side: random stalls, plus a long hold-off on demand
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    logic ready;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      ready = cfg_ready;
      @(posedge clk);
    end while (!ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] m, logic [15:0] ch, logic [15:0] mx,
                           logic [15:0] gm);
    drain();
    write_reg(REG_MODE, m);
    write_reg(REG_CHAN_SEL, ch);
    write_reg(REG_MAX_IN, mx);
    write_reg(REG_GRAY_MAX, gm);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_level(logic [15:0] lim);
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 2 ** 16 - 1));
      1: return lim;
      default: return 16'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    if ($urandom_range(1)) return 16'($urandom_range(0, 2 ** 16 - 1));
    return 16'($urandom_range(0, pix_span));
  endfunction

  initial begin
    logic [15:0] m;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: max_in at 255, either side of the dark boundary
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'hffff, 16'hffff, 16'hffff);
    send_pixel(16'd127, 16'd127, 16'd128);
    send_pixel(16'd128, 16'd127, 16'd128);
    configure(MODE_GRAY, CH_RED, 16'd255, 16'd65535);
    send_pixel(16'd255, 16'd255, 16'd255);
    send_pixel(16'hffff, 16'd0, 16'hffff);       // above max_in, saturates
    send_pixel(16'd1, 16'd0, 16'd0);
    configure(MODE_GRAY, CH_RED, 16'd100, 16'd0);  // gray_max zero
    send_pixel(16'd90, 16'd80, 16'd70);
    configure(MODE_ISOLATE, CH_BLUE, 16'd255, 16'd255);
    send_pixel(16'd11, 16'd22, 16'd33);
    configure(MODE_ISOLATE, 16'd3, 16'd255, 16'd255);  // no channel kept
    send_pixel(16'd11, 16'd22, 16'd33);
    configure(MODE_REMOVE, 16'd3, 16'd255, 16'd255);   // passes through
    send_pixel(16'hffff, 16'h8001, 16'h7ffe);
    configure(MODE_REMOVE, CH_GREEN, 16'd255, 16'd255);
    send_pixel(16'hffff, 16'h8001, 16'h7ffe);
    configure(MODE_SEPIA, CH_RED, 16'd65535, 16'd255);
    send_pixel(16'hffff, 16'hffff, 16'hffff);
    send_pixel(16'd100, 16'd50, 16'd25);
    configure(MODE_SEPIA, CH_RED, 16'd0, 16'd255);      // max_in zero
    send_pixel(16'd100, 16'd50, 16'd25);
    configure(MODE_BITMAP, CH_RED, 16'd0, 16'd255);
    send_pixel(16'd0, 16'd0, 16'd0);
    configure(MODE_GRAY, CH_RED, 16'd0, 16'd255);
    send_pixel(16'd5, 16'd5, 16'd5);
    configure(16'd5, CH_RED, 16'd255, 16'd255);
    send_pixel(16'd5, 16'd5, 16'd5);
    configure(16'd7, CH_RED, 16'd255, 16'd255);
    send_pixel(16'd5, 16'd5, 16'd5);

    for (int p = 0; p < 25; p++) begin
      m = ($urandom_range(9) == 0) ? 16'($urandom_range(5, 7)) : 16'($urandom_range(0, 4));
      pix_span = (p % 5 == 0) ? 16'hffff : pick_level(16'($urandom_range(1, 65535)));
      configure(m, 16'($urandom_range(0, 3)), pix_span, pick_level(16'hffff));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      if (p == 4 || p == 16) hold_req++;  // long hold-off, input keeps pushing
      for (int i = 0; i < 50; i++)
        send_pixel(pick_sample(), pick_sample(), pick_sample());
    end

    drain();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* rgb_pixel_point_transform_top.f */
src/rgbpt_pkg.sv
src/rgbpt_div_pipe.sv
src/rgb_pixel_point_transform_top.sv
src/rgbpt_checker.sv
verif/rgbpt_checker.sv
verif/rgb_pixel_point_transform_top_tb.sv
